FILE: src/psart_pkg.sv
// Shared types and constants for the per-source accept rate table.
// Holds the entry record layout, operation and status codes, and the scan result bundle.
// No dependencies.
package psart_pkg;

    // default table depth
    localparam int DEF_TABLE_ENTRIES = 64;

    // accept window rules
    localparam logic [31:0] WINDOW_SECS = 32'd60;
    localparam logic [14:0] COUNT_CEIL  = 15'd20000;

    // operation codes
    typedef enum logic [2:0] {
        MODE_ADD    = 3'd0,
        MODE_DELETE = 3'd1,
        MODE_ACCEPT = 3'd2,
        MODE_TOUCH  = 3'd3,
        MODE_QUERY  = 3'd4,
        MODE_DOMAIN = 3'd5
    } mode_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    // one table entry as stored in memory
    typedef struct packed {
        logic        vld;
        logic [31:0] addr;
        logic [31:0] last_req;
        logic [31:0] win_start;
        logic [14:0] accepts;
    } entry_t;

    // accumulated outcome of one sweep over the table
    typedef struct packed {
        logic        hit;
        logic        free;
        logic        dom;
        logic [31:0] hit_last;
        logic [31:0] hit_ws;
        logic [14:0] hit_acc;
        logic [31:0] dom_last;
    } scan_res_t;

endpackage

FILE: src/per_source_accept_rate_table.sv
// Per-source accept rate table: top level with entry memory, sequencer and output register.
// Transactions are handled one at a time: each sweeps the entry memory one entry per cycle,
// and a new transaction is taken only after the previous result is loaded into the output
// register. After reset a clearing pass zeroes every entry, valid bits included; no input is
// taken meanwhile. Depends on psart_pkg, psart_scan.
module per_source_accept_rate_table #(
    parameter int TABLE_ENTRIES = psart_pkg::DEF_TABLE_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [31:0] s_src_addr,
    input  logic [31:0] s_when,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [14:0] m_accept_count,
    output logic [31:0] m_last_request,
    output logic        m_over_limit
);
    import psart_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_CALC   = 5'b01000,
        ST_COMMIT = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             eval_reg, eval_next;
    logic [IDX_W-1:0] eval_idx_reg;
    logic [14:0]      limit_reg;
    logic             m_valid_reg;

    // request holding registers
    mode_t            mode_reg;
    logic [31:0]      key_reg;
    logic [31:0]      now_reg;

    // entry memory
    entry_t           mem [TABLE_ENTRIES];
    entry_t           rd_rec_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;

    // commit stage registers
    logic             wr_en_reg, wr_en_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    entry_t           wr_rec_reg, wr_rec_next;
    status_t          res_status_reg, res_status_next;
    logic [14:0]      res_count_reg, res_count_next;
    logic [31:0]      res_last_reg, res_last_next;

    scan_res_t        scan_res;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] free_idx;

    logic             in_acc;
    logic             out_load;
    logic             lim_on;
    logic [16:0]      lim3;
    logic [14:0]      lim_thr;
    logic [14:0]      fold_val;
    logic [31:0]      ws_diff;
    logic             gap;
    logic [14:0]      acc_inc;
    logic [14:0]      acc_new;
    logic [31:0]      ws_new;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign out_load = (state_reg == ST_COMMIT) && (!m_valid_reg || m_ready);

    // limit register, saturated on write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= '0;
        end else if (cfg_wr_en) begin
            limit_reg <= (cfg_wr_data > COUNT_CEIL) ? COUNT_CEIL : cfg_wr_data;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        eval_next  = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
            end
            ST_IDLE: begin
                cnt_next = '0;
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_reg != CNT_END) begin
                    cnt_next  = cnt_reg + 1'b1;
                    eval_next = 1'b1;
                end else begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            eval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            eval_reg  <= eval_next;
        end
    end

    // latch the request on an input transaction
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            mode_reg <= mode_t'(s_mode);
            key_reg  <= s_src_addr;
            now_reg  <= s_when;
        end
        eval_idx_reg <= cnt_reg[IDX_W-1:0];
    end

    // memory write port: clearing pass or commit
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_reg[IDX_W-1:0];
            mem_wdata = '0;
        end else begin
            mem_we    = (state_reg == ST_COMMIT) && wr_en_reg;
            mem_waddr = wr_idx_reg;
            mem_wdata = wr_rec_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_rec_reg <= mem[cnt_reg[IDX_W-1:0]];
    end

    psart_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (in_acc),
        .eval     (eval_reg),
        .eval_idx (eval_idx_reg),
        .rec      (rd_rec_reg),
        .key      (key_reg),
        .res      (scan_res),
        .hit_idx  (hit_idx),
        .free_idx (free_idx)
    );

    // accept counting rules
    assign lim_on   = (limit_reg > 15'd1);
    assign lim3     = {2'b00, limit_reg} + {1'b0, limit_reg, 1'b0};
    assign lim_thr  = lim3[16:2];
    assign fold_val = (lim_on ? limit_reg : 15'd1) + 15'd1;
    assign ws_diff  = now_reg - scan_res.hit_ws;
    assign gap      = (now_reg > scan_res.hit_ws) && (ws_diff > WINDOW_SECS);
    assign acc_inc  = scan_res.hit_acc + 15'd1;

    always_comb begin
        if (gap) begin
            ws_new  = now_reg;
            acc_new = 15'd1;
        end else begin
            ws_new  = (lim_on && (scan_res.hit_acc > lim_thr)) ? now_reg : scan_res.hit_ws;
            acc_new = (acc_inc > COUNT_CEIL) ? fold_val : acc_inc;
        end
    end

    // per-operation update and result
    always_comb begin
        wr_en_next      = 1'b0;
        wr_idx_next     = hit_idx;
        wr_rec_next     = '{vld: 1'b1, addr: key_reg, last_req: scan_res.hit_last,
                            win_start: scan_res.hit_ws, accepts: scan_res.hit_acc};
        res_status_next = STAT_MISS;
        res_count_next  = '0;
        res_last_next   = '0;
        unique case (mode_reg)
            MODE_ADD: begin
                if (!scan_res.hit) begin
                    wr_idx_next = free_idx;
                end
                if (scan_res.hit || scan_res.free) begin
                    wr_en_next      = 1'b1;
                    wr_rec_next     = '{vld: 1'b1, addr: key_reg, last_req: now_reg,
                                        win_start: now_reg, accepts: 15'd0};
                    res_status_next = STAT_OK;
                    res_last_next   = now_reg;
                end else begin
                    res_status_next = STAT_FULL;
                end
            end
            MODE_DELETE: begin
                if (scan_res.hit) begin
                    wr_en_next      = 1'b1;
                    wr_rec_next.vld = 1'b0;
                    res_status_next = STAT_OK;
                end
            end
            MODE_ACCEPT: begin
                if (scan_res.hit) begin
                    wr_en_next            = 1'b1;
                    wr_rec_next.win_start = ws_new;
                    wr_rec_next.accepts   = acc_new;
                    res_status_next       = STAT_OK;
                    res_count_next        = acc_new;
                    res_last_next         = scan_res.hit_last;
                end
            end
            MODE_TOUCH: begin
                if (scan_res.hit) begin
                    wr_en_next           = 1'b1;
                    wr_rec_next.last_req = now_reg;
                    res_status_next      = STAT_OK;
                    res_count_next       = scan_res.hit_acc;
                    res_last_next        = now_reg;
                end
            end
            MODE_QUERY: begin
                if (scan_res.hit) begin
                    res_status_next = STAT_OK;
                    res_count_next  = scan_res.hit_acc;
                    res_last_next   = scan_res.hit_last;
                end
            end
            MODE_DOMAIN: begin
                if (scan_res.dom) begin
                    res_status_next = STAT_OK;
                    res_last_next   = scan_res.dom_last;
                end
            end
            default: begin
                res_status_next = STAT_MISS;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CALC) begin
            wr_en_reg      <= wr_en_next;
            wr_idx_reg     <= wr_idx_next;
            wr_rec_reg     <= wr_rec_next;
            res_status_reg <= res_status_next;
            res_count_reg  <= res_count_next;
            res_last_reg   <= res_last_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status       <= res_status_reg;
            m_accept_count <= res_count_reg;
            m_last_request <= res_last_reg;
            m_over_limit   <= lim_on && (res_count_reg >= limit_reg);
        end
    end

    assign m_valid = m_valid_reg;

    // an input transaction always starts a sweep
    a_acc_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> (state_reg == ST_SCAN))
        else $error("sweep did not start after input transaction");

    // sweep counter never exceeds the table depth
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_END)
        else $error("sweep counter out of range");

    // a miss or refusal carries no count and no limit flag
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STAT_OK)) |-> ((m_accept_count == '0) && !m_over_limit))
        else $error("nonzero count on failed lookup");

    // limit flag only with the limit enabled
    a_over_lim: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_over_limit) |-> (limit_reg > 15'd1))
        else $error("over-limit flag with limit disabled");

    // memory is written only during clearing or commit
    a_wr_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> ((state_reg == ST_CLEAR) || (state_reg == ST_COMMIT)))
        else $error("memory write outside clear or commit");

endmodule

FILE: src/psart_scan.sv
// Sweep compare unit: checks one table entry per cycle against the request key.
// Tracks the first match, the first free slot and the latest request in the /16.
// Depends on psart_pkg.
module psart_scan #(
    parameter int IDX_W = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 clear,
    input  logic                 eval,
    input  logic [IDX_W-1:0]     eval_idx,
    input  psart_pkg::entry_t    rec,
    input  logic [31:0]          key,
    output psart_pkg::scan_res_t res,
    output logic [IDX_W-1:0]     hit_idx,
    output logic [IDX_W-1:0]     free_idx
);
    import psart_pkg::*;

    scan_res_t        res_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             is_match;
    logic             is_dom;

    // per-entry compares
    assign is_match = rec.vld && (rec.addr == key);
    assign is_dom   = rec.vld && (rec.addr[31:16] == key[31:16]);

    // accumulate over the sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg <= '0;
        end else if (clear) begin
            res_reg <= '0;
        end else if (eval) begin
            if (is_match && !res_reg.hit) begin
                res_reg.hit      <= 1'b1;
                res_reg.hit_last <= rec.last_req;
                res_reg.hit_ws   <= rec.win_start;
                res_reg.hit_acc  <= rec.accepts;
            end
            if (!rec.vld && !res_reg.free) begin
                res_reg.free <= 1'b1;
            end
            if (is_dom) begin
                res_reg.dom <= 1'b1;
                if (rec.last_req > res_reg.dom_last) begin
                    res_reg.dom_last <= rec.last_req;
                end
            end
        end
    end

    // slot indexes need no reset, qualified by the flags
    always_ff @(posedge aclk) begin
        if (eval && is_match && !res_reg.hit) begin
            hit_idx_reg <= eval_idx;
        end
        if (eval && !rec.vld && !res_reg.free) begin
            free_idx_reg <= eval_idx;
        end
    end

    assign res      = res_reg;
    assign hit_idx  = hit_idx_reg;
    assign free_idx = free_idx_reg;

endmodule

FILE: tb/rate_table_monitor.sv
// Watching checker for the per-source accept rate table: follows both channels and the limit register.
// It keeps its own copy of the source table, predicts each result and compares it field by field.
// Depends on psart_pkg.
module rate_table_monitor #(
    parameter int TABLE_ENTRIES = psart_pkg::DEF_TABLE_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [31:0] s_src_addr,
    input  logic [31:0] s_when,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [14:0] m_accept_count,
    input  logic [31:0] m_last_request,
    input  logic        m_over_limit,
    output int          mismatches,
    output int          outstanding
);
    import psart_pkg::*;

    // one predicted result plus the transaction that caused it
    typedef struct packed {
        status_t     status;
        logic [14:0] count;
        logic [31:0] last_req;
        logic        over;
        logic [2:0]  op;
        logic [31:0] addr;
    } outcome_t;

    // shadow copy of the source table and the limit register
    bit          valid_tab  [TABLE_ENTRIES];
    logic [31:0] addr_tab   [TABLE_ENTRIES];
    logic [31:0] last_tab   [TABLE_ENTRIES];
    logic [31:0] wstart_tab [TABLE_ENTRIES];
    logic [14:0] count_tab  [TABLE_ENTRIES];
    int unsigned limit_now;

    outcome_t lookup_outcomes[$];
    int       miss_total;

    initial begin
        mismatches  = 0;
        outstanding = 0;
        miss_total  = 0;
        limit_now   = 0;
    end

    // limit flag: only armed when the limit is above one
    function automatic logic over_mark(input int unsigned cnt);
        return (limit_now > 1) && (cnt >= limit_now);
    endfunction

    // apply one operation to the shadow table and return what the block should answer
    function automatic outcome_t apply_table_op(input logic [2:0] op, input logic [31:0] addr,
                                                input logic [31:0] t);
        outcome_t    res;
        int          hit;
        int          spot;
        int          i;
        int unsigned cnt;
        logic [31:0] ws;
        res        = '0;
        res.status = STAT_MISS;
        res.op     = op;
        res.addr   = addr;
        hit        = -1;
        for (i = 0; i < TABLE_ENTRIES; i++)
            if (hit < 0 && valid_tab[i] && addr_tab[i] == addr)
                hit = i;
        case (op)
            MODE_ADD: begin
                // present address is overwritten, otherwise lowest free slot
                spot = hit;
                if (spot < 0)
                    for (i = 0; i < TABLE_ENTRIES; i++)
                        if (spot < 0 && !valid_tab[i])
                            spot = i;
                if (spot < 0) begin
                    res.status = STAT_FULL;
                end else begin
                    valid_tab[spot]  = 1'b1;
                    addr_tab[spot]   = addr;
                    last_tab[spot]   = t;
                    wstart_tab[spot] = t;
                    count_tab[spot]  = '0;
                    res.status       = STAT_OK;
                    res.last_req     = t;
                end
            end
            MODE_DELETE: begin
                if (hit >= 0) begin
                    valid_tab[hit] = 1'b0;
                    res.status     = STAT_OK;
                end
            end
            MODE_ACCEPT: begin
                if (hit >= 0) begin
                    ws  = wstart_tab[hit];
                    cnt = 32'(count_tab[hit]);
                    // gap past the window restarts the count; backwards time is no gap
                    if (t > ws && (t - ws) > WINDOW_SECS) begin
                        wstart_tab[hit] = t;
                        cnt = 1;
                    end else begin
                        if (limit_now > 1 && cnt > (limit_now * 3) / 4)
                            wstart_tab[hit] = t;
                        cnt = cnt + 1;
                        if (cnt > COUNT_CEIL)
                            cnt = ((limit_now > 1) ? limit_now : 1) + 1;
                    end
                    count_tab[hit] = cnt[14:0];
                    res.status     = STAT_OK;
                    res.count      = cnt[14:0];
                    res.last_req   = last_tab[hit];
                    res.over       = over_mark(cnt);
                end
            end
            MODE_TOUCH, MODE_QUERY: begin
                if (hit >= 0) begin
                    if (op == MODE_TOUCH)
                        last_tab[hit] = t;
                    res.status   = STAT_OK;
                    res.count    = count_tab[hit];
                    res.last_req = last_tab[hit];
                    res.over     = over_mark(32'(count_tab[hit]));
                end
            end
            MODE_DOMAIN: begin
                // latest request among sources in the same /16
                for (i = 0; i < TABLE_ENTRIES; i++)
                    if (valid_tab[i] && addr_tab[i][31:16] == addr[31:16]) begin
                        res.status = STAT_OK;
                        if (last_tab[i] > res.last_req)
                            res.last_req = last_tab[i];
                    end
            end
            default: ;
        endcase
        return res;
    endfunction

    // follow register writes and both channels at each rising edge
    always @(posedge aclk) begin : watch
        outcome_t want;
        logic     bad;
        int       k;
        if (!aresetn) begin
            for (k = 0; k < TABLE_ENTRIES; k++)
                valid_tab[k] = 1'b0;
            limit_now = 0;
            lookup_outcomes.delete();
        end else begin
            if (cfg_wr_en)
                limit_now = 32'((cfg_wr_data > COUNT_CEIL) ? COUNT_CEIL : cfg_wr_data);
            // result transaction against the oldest prediction
            if (m_valid && m_ready) begin
                if (lookup_outcomes.size() == 0) begin
                    miss_total++;
                    if (miss_total <= 10)
                        $display("unexpected result: status %0d count %0d last %h over %0d",
                                 m_status, m_accept_count, m_last_request, m_over_limit);
                end else begin
                    want = lookup_outcomes.pop_front();
                    bad  = (m_status !== want.status) || (m_accept_count !== want.count) ||
                           (m_last_request !== want.last_req) || (m_over_limit !== want.over);
                    if (bad) begin
                        miss_total++;
                        if (miss_total <= 10)
                            $display({"mismatch mode %0d addr %h: status %0d/%0d ",
                                      "count %0d/%0d last %h/%h over %0d/%0d (exp/got)"},
                                     want.op, want.addr, want.status, m_status,
                                     want.count, m_accept_count, want.last_req,
                                     m_last_request, want.over, m_over_limit);
                    end
                end
            end
            // input transaction
            if (s_valid && s_ready)
                lookup_outcomes.push_back(apply_table_op(s_mode, s_src_addr, s_when));
        end
        mismatches  <= miss_total;
        outstanding <= lookup_outcomes.size();
    end

endmodule

FILE: tb/testbench.sv
// Top of the accept rate table bench: clock, reset, stimulus, receiver stalls and the verdict.
// Instantiates per_source_accept_rate_table and rate_table_monitor; depends on psart_pkg.
module testbench;
    import psart_pkg::*;

    localparam int TABLE_ENTRIES = DEF_TABLE_ENTRIES;
    localparam int POOL_SIZE     = 20;
    localparam int FLOOD_SIZE    = 70;

    // mode encodings the block does not use
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [14:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_mode;
    logic [31:0] s_src_addr;
    logic [31:0] s_when;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [14:0] m_accept_count;
    logic [31:0] m_last_request;
    logic        m_over_limit;

    int          mismatches;
    int          outstanding;
    bit          send_jitter;
    bit          recv_jitter;
    int          stall_left;
    logic [31:0] clock_s;
    logic [31:0] pool [POOL_SIZE];
    logic [31:0] flood [FLOOD_SIZE];

    per_source_accept_rate_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_src_addr    (s_src_addr),
        .s_when        (s_when),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_accept_count(m_accept_count),
        .m_last_request(m_last_request),
        .m_over_limit  (m_over_limit)
    );

    rate_table_monitor #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_monitor (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_src_addr    (s_src_addr),
        .s_when        (s_when),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_accept_count(m_accept_count),
        .m_last_request(m_last_request),
        .m_over_limit  (m_over_limit),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // receiver stalls in random bursts while receiver jitter is on
    always @(negedge aclk) begin
        if (!aresetn || !recv_jitter) begin
            stall_left = 0;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // one input transaction, optionally after an idle burst
    task automatic push_item(input logic [2:0] op, input logic [31:0] addr,
                             input logic [31:0] t);
        int gap;
        if (send_jitter && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_mode     <= op;
        s_src_addr <= addr;
        s_when     <= t;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop sending and wait for every predicted result
    task automatic settle();
        @(negedge aclk) s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    // limit register write while the block is idle
    task automatic set_limit(input logic [14:0] v);
        settle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk) cfg_wr_en <= 1'b0;
    endtask

    // mostly well-formed traffic on a small pool of sources, some noise
    task automatic random_item();
        int          r;
        int          drift;
        logic [2:0]  op;
        logic [31:0] addr;
        logic [31:0] low;
        drift = $urandom_range(0, 19);
        if (drift < 14)
            clock_s = clock_s + $urandom_range(0, 3);
        else if (drift < 17)
            clock_s = clock_s + $urandom_range(55, 130);
        else if (drift < 19)
            clock_s = clock_s - $urandom_range(1, 40);
        else
            clock_s = $urandom();
        addr = pool[$urandom_range(0, POOL_SIZE - 1)];
        r    = $urandom_range(0, 99);
        if (r < 12)
            op = MODE_ADD;
        else if (r < 20)
            op = MODE_DELETE;
        else if (r < 55)
            op = MODE_ACCEPT;
        else if (r < 65)
            op = MODE_TOUCH;
        else if (r < 77)
            op = MODE_QUERY;
        else if (r < 90) begin
            op   = MODE_DOMAIN;
            low  = $urandom();
            addr = {addr[31:16], low[15:0]};
        end else if (r < 93)
            op = r[0] ? MODE_SPARE_A : MODE_SPARE_B;
        else begin
            op   = 3'($urandom_range(0, 7));
            addr = $urandom();
        end
        push_item(op, addr, clock_s);
    endtask

    // one limit setting with random traffic, idling re-drawn every 50 transactions
    task automatic run_phase(input logic [14:0] v, input int n);
        int j;
        set_limit(v);
        for (j = 0; j < n; j++) begin
            if (j % 50 == 0) begin
                send_jitter = ($urandom_range(0, 3) != 0);
                recv_jitter = ($urandom_range(0, 3) != 0);
            end
            random_item();
        end
    endtask

    // stimulus and verdict
    initial begin : stimulus
        logic [31:0] prefix;
        logic [31:0] low;
        int          i;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_mode      <= MODE_QUERY;
        s_src_addr  <= '0;
        s_when      <= '0;
        send_jitter = 1'b1;
        recv_jitter = 1'b1;
        clock_s     = 32'd1000;

        // source pool: two shared /16 groups plus scattered sources
        prefix = $urandom();
        for (i = 0; i < POOL_SIZE; i++) begin
            low = $urandom();
            if (i == 8)
                prefix = $urandom();
            pool[i] = (i < 14) ? {prefix[31:16], low[15:0]} : low;
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // directed: misses on an empty table, field extremes, window rules
        set_limit(15'd4);
        push_item(MODE_QUERY,   32'h1234_0001, 32'd5);
        push_item(MODE_DOMAIN,  32'h1234_0001, 32'd5);
        push_item(MODE_DELETE,  32'h1234_0001, 32'd5);
        push_item(MODE_ACCEPT,  32'h1234_0001, 32'd5);
        push_item(MODE_TOUCH,   32'h1234_0001, 32'd5);
        push_item(MODE_ADD,     32'h0000_0000, 32'd0);
        push_item(MODE_ADD,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(MODE_ADD,     32'h1234_0001, 32'd100);
        push_item(MODE_ADD,     32'h1234_ABCD, 32'd50);
        push_item(MODE_DOMAIN,  32'h1234_FFFF, 32'd0);
        push_item(MODE_ACCEPT,  32'h1234_0001, 32'd100);
        // gap of exactly the window keeps the count, one more restarts it
        push_item(MODE_ACCEPT,  32'h1234_0001, 32'd160);
        push_item(MODE_ACCEPT,  32'h1234_0001, 32'd161);
        // time going backwards is no gap
        push_item(MODE_ACCEPT,  32'h1234_0001, 32'd150);
        // climb past three quarters of the limit and reach it
        push_item(MODE_ACCEPT,  32'h1234_0001, 32'd170);
        push_item(MODE_ACCEPT,  32'h1234_0001, 32'd170);
        push_item(MODE_ACCEPT,  32'h1234_0001, 32'd170);
        push_item(MODE_TOUCH,   32'h1234_0001, 32'd500);
        push_item(MODE_QUERY,   32'h1234_0001, 32'd0);
        // add of a present source overwrites it
        push_item(MODE_ADD,     32'h1234_0001, 32'd7);
        push_item(MODE_DELETE,  32'h0000_0000, 32'd0);
        push_item(MODE_QUERY,   32'h0000_0000, 32'd0);
        push_item(MODE_SPARE_A, 32'h1234_0001, 32'hFFFF_FFFF);
        push_item(MODE_SPARE_B, 32'hFFFF_FFFF, 32'd0);
        push_item(MODE_ACCEPT,  32'hFFFF_FFFF, 32'd0);
        push_item(MODE_DOMAIN,  32'hFFFF_0000, 32'd0);

        // random traffic across limit settings, out-of-range write saturates
        run_phase(15'd0, 160);
        run_phase(15'd1, 160);
        run_phase(15'd2, 160);
        run_phase(15'd3, 160);
        run_phase(15'($urandom_range(4, 12)), 160);
        run_phase(15'd20000, 160);
        run_phase(15'h7FFF, 160);

        // fill the table until adds are refused, then free it again
        set_limit(15'($urandom_range(2, 6)));
        for (i = 0; i < FLOOD_SIZE; i++) begin
            flood[i] = $urandom();
            push_item(MODE_ADD, flood[i], clock_s + i);
        end
        for (i = 0; i < 20; i++)
            random_item();
        for (i = 0; i < FLOOD_SIZE; i++)
            push_item(MODE_DELETE, flood[i], clock_s);

        // last part without idling: back-to-back accepts on one source
        send_jitter = 1'b0;
        recv_jitter = 1'b0;
        set_limit(15'd0);
        push_item(MODE_ADD, pool[0], 32'd1000);
        for (i = 0; i < 30; i++)
            push_item(MODE_ACCEPT, pool[0], 32'd1000);
        set_limit(15'd20000);
        push_item(MODE_ACCEPT, pool[0], 32'd1000);
        push_item(MODE_ACCEPT, pool[0], 32'd1000);
        set_limit(15'd0);
        push_item(MODE_ACCEPT, pool[0], 32'd1000);
        push_item(MODE_QUERY,  pool[0], 32'd0);
        set_limit(15'd2);
        for (i = 0; i < 60; i++)
            random_item();

        // drain and let the block go quiet
        settle();
        repeat (TABLE_ENTRIES + 8) @(posedge aclk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // run limit
    initial begin
        #(64'd60_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule
